@@ rtl/tcse_pkg.sv @@
// Package for the tone curve spline evaluator.
// Holds widths, fixed-point constants, the controller state and datapath
// command types shared by tcse_ctrl, tcse_dp and the top level.
`default_nettype none
package tcse_pkg;

  localparam int MaxPoints = 16;
  localparam int FracBits  = 16;
  localparam int IdxW      = 4;
  localparam int CntW      = 5;
  localparam int ValW      = FracBits + 1;
  localparam int DifW      = ValW + 1;
  localparam int NumW      = 2 * DifW - 2;
  localparam int HornW     = 40;
  localparam int ProdW     = HornW + DifW;

  localparam logic [ValW-1:0] OneQ  = ValW'(1) << FracBits;
  localparam logic [ValW-1:0] HalfQ = ValW'(1) << (FracBits - 1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_FIRST,
    OP_LAST,
    OP_SRCH,
    OP_LD0,
    OP_LD1,
    OP_LD2,
    OP_LD3,
    OP_DT_GO,
    OP_CAP_T,
    OP_MUL_M1,
    OP_DM1_GO,
    OP_CAP_M1,
    OP_MUL_M2,
    OP_DM2_GO,
    OP_CAP_M2,
    OP_COEF,
    OP_HMUL,
    OP_HADD,
    OP_CLAMP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SRCH,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_T_GO,
    ST_T_WAIT,
    ST_M1_MUL,
    ST_M1_GO,
    ST_M1_WAIT,
    ST_M2_MUL,
    ST_M2_GO,
    ST_M2_WAIT,
    ST_COEF,
    ST_HMUL,
    ST_HADD,
    ST_CLAMP,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic lt;
    logic srch_done;
    logic div_done;
    logic h_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/tcse_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// A zero divisor gives a zero quotient. Depends on tcse_pkg.
`default_nettype none
module tcse_div
  import tcse_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [NumW-1:0] num,
  input  wire logic signed [DifW-1:0] den,
  output logic                        done,
  output logic signed [NumW-1:0]      quo
);

  localparam int CW = $clog2(NumW + 1);

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            neg_r, neg_nxt;
  logic            zden_r, zden_nxt;
  logic [DifW-1:0] den_r, den_nxt;
  logic [DifW:0]   rem_r, rem_nxt;
  logic [NumW-1:0] q_r, q_nxt;
  logic [DifW:0]   rem_s;
  logic            qbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r  <= neg_nxt;
    zden_r <= zden_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    zden_nxt = zden_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    rem_s    = {rem_r[DifW-1:0], q_r[NumW-1]};
    qbit     = (rem_s >= {1'b0, den_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NumW);
      neg_nxt  = num[NumW-1] ^ den[DifW-1];
      zden_nxt = (den == '0);
      den_nxt  = den[DifW-1] ? DifW'(-den) : DifW'(den);
      rem_nxt  = '0;
      q_nxt    = num[NumW-1] ? NumW'(-num) : NumW'(num);
    end else if (busy_r) begin
      rem_nxt = qbit ? rem_s - {1'b0, den_r} : rem_s;
      q_nxt   = {q_r[NumW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = zden_r ? '0 : (neg_r ? -$signed(q_r) : $signed(q_r));

endmodule
`default_nettype wire

@@ rtl/tcse_dp.sv @@
// Datapath: knot tables, point count register, search index, point fetch,
// divider, Horner evaluation and output register. Depends on tcse_pkg, tcse_div.
`default_nettype none
module tcse_dp
  import tcse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ctl_cmd_t        cmd,
  output dp_stat_t             stat,
  input  wire logic [IdxW-1:0] in_point_index,
  input  wire logic [ValW-1:0] in_point_x,
  input  wire logic [ValW-1:0] in_point_y,
  input  wire logic [ValW-1:0] in_sample_x,
  input  wire logic            cfg_valid,
  input  wire logic [CntW-1:0] cfg_point_count,
  output logic [ValW-1:0]      out_curve_value,
  output logic                 out_valid,
  input  wire logic            out_ready
);

  logic [ValW-1:0] kx_mem [MaxPoints];
  logic [ValW-1:0] ky_mem [MaxPoints];

  logic [CntW-1:0] pc_r;
  logic [CntW-1:0] n_r;
  logic [IdxW-1:0] i_r;
  logic [ValW-1:0] xs_r;
  logic [ValW-1:0] x0_r, x1_r, x2_r, x3_r, y0_r, y1_r, y2_r, y3_r;
  logic [ValW-1:0] res_r;
  logic [ValW-1:0] t_r;
  logic signed [NumW-1:0]  prod_r;
  logic signed [NumW-1:0]  c2_r;
  logic signed [DifW-1:0]  m2_r;
  logic signed [HornW-1:0] v_r, c1_r;
  logic signed [ProdW-1:0] hp_r;
  logic [1:0]      hk_r;
  logic [ValW-1:0] out_r;
  logic            out_valid_r;

  logic [IdxW-1:0] ridx, n_last, i0, i2, i3;
  logic [ValW-1:0] kx_rd, ky_rd;
  logic [CntW:0]   ip2;
  logic signed [DifW-1:0] h, dx, dy20, dy31, dx20, dx31;
  logic div_start;
  logic signed [NumW-1:0] div_num, div_quo;
  logic signed [DifW-1:0] div_den;
  logic div_done;
  logic signed [HornW-1:0] c0, c1, hq, cadd;
  logic signed [ProdW-1:0] hp_adj;

  function automatic logic [ValW-1:0] sat_one(input logic [ValW-1:0] v);
    return (v > OneQ) ? OneQ : v;
  endfunction

  function automatic logic signed [DifW-1:0] sdiff(input logic [ValW-1:0] a,
                                                   input logic [ValW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  assign n_last = IdxW'(n_r - CntW'(1));
  assign i0     = (i_r == '0) ? '0 : i_r - IdxW'(1);
  assign ip2    = (CntW+1)'(i_r) + (CntW+1)'(2);
  assign i2     = (ip2 > (CntW+1)'(n_last)) ? n_last : i_r + IdxW'(1);
  assign i3     = (ip2 > (CntW+1)'(n_last)) ? n_last : IdxW'(ip2);

  always_comb begin
    case (cmd.op)
      OP_LAST: ridx = n_last;
      OP_SRCH: ridx = i_r;
      OP_LD0:  ridx = i0;
      OP_LD1:  ridx = i_r;
      OP_LD2:  ridx = i2;
      OP_LD3:  ridx = i3;
      default: ridx = '0;
    endcase
  end

  assign kx_rd = kx_mem[ridx];
  assign ky_rd = ky_mem[ridx];

  assign h    = sdiff(x2_r, x1_r);
  assign dx   = sdiff(xs_r, x1_r);
  assign dy20 = sdiff(y2_r, y0_r);
  assign dy31 = sdiff(y3_r, y1_r);
  assign dx20 = sdiff(x2_r, x0_r);
  assign dx31 = sdiff(x3_r, x1_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = prod_r;
    div_den   = dx20;
    case (cmd.op)
      OP_DT_GO: begin
        div_start = 1'b1;
        div_num   = NumW'({dx, {FracBits{1'b0}}});
        div_den   = h;
      end
      OP_DM1_GO: begin
        div_start = 1'b1;
      end
      OP_DM2_GO: begin
        div_start = 1'b1;
        div_den   = dx31;
      end
      default: ;
    endcase
  end

  tcse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign c0 = HornW'(2 * $signed({1'b0, y1_r})) - HornW'(2 * $signed({1'b0, y2_r}))
            + HornW'(c2_r) + HornW'(m2_r);
  assign c1 = HornW'($signed({1'b0, y2_r})) - HornW'($signed({1'b0, y1_r}))
            - HornW'(c2_r) - c0;

  assign hp_adj = hp_r + (hp_r[ProdW-1] ? ProdW'((1 << FracBits) - 1) : ProdW'(0));
  assign hq     = HornW'(hp_adj >>> FracBits);

  always_comb begin
    case (hk_r)
      2'd0:    cadd = c1_r;
      2'd1:    cadd = HornW'(c2_r);
      default: cadd = HornW'($signed({1'b0, y1_r}));
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      kx_mem[in_point_index] <= sat_one(in_point_x);
      ky_mem[in_point_index] <= sat_one(in_point_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= CntW'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) pc_r <= cfg_point_count;
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        xs_r <= in_sample_x;
        n_r  <= (pc_r > CntW'(MaxPoints)) ? CntW'(MaxPoints) : pc_r;
        i_r  <= '0;
      end
      OP_FIRST: res_r <= (n_r == '0) ? HalfQ : ky_rd;
      OP_LAST:  res_r <= ky_rd;
      OP_SRCH: begin
        if (!stat.srch_done) i_r <= i_r + IdxW'(1);
        else if (i_r != '0) i_r <= i_r - IdxW'(1);
      end
      OP_LD0: begin x0_r <= kx_rd; y0_r <= ky_rd; end
      OP_LD1: begin x1_r <= kx_rd; y1_r <= ky_rd; end
      OP_LD2: begin x2_r <= kx_rd; y2_r <= ky_rd; end
      OP_LD3: begin x3_r <= kx_rd; y3_r <= ky_rd; end
      OP_CAP_T:  t_r <= ValW'(div_quo);
      OP_MUL_M1: prod_r <= NumW'(dy20 * h);
      OP_CAP_M1: c2_r <= div_quo;
      OP_MUL_M2: prod_r <= NumW'(dy31 * h);
      OP_CAP_M2: begin
        if (div_quo > NumW'($signed({1'b0, OneQ})))
          m2_r <= DifW'($signed({1'b0, OneQ}));
        else if (div_quo < -NumW'($signed({1'b0, OneQ})))
          m2_r <= -DifW'($signed({1'b0, OneQ}));
        else
          m2_r <= DifW'(div_quo);
      end
      OP_COEF: begin
        v_r  <= c0;
        c1_r <= c1;
        hk_r <= '0;
      end
      OP_HMUL: hp_r <= v_r * $signed({1'b0, t_r});
      OP_HADD: begin
        v_r  <= hq + cadd;
        hk_r <= hk_r + 2'd1;
      end
      OP_CLAMP: begin
        if (v_r < 0) res_r <= '0;
        else if (v_r > HornW'($signed({1'b0, OneQ}))) res_r <= OneQ;
        else res_r <= ValW'(v_r);
      end
      OP_OUT: out_r <= res_r;
      default: ;
    endcase
  end

  always_comb begin
    stat.n_zero    = (n_r == '0);
    stat.lt        = (xs_r < kx_rd);
    stat.srch_done = (i_r == n_last) || (xs_r < kx_rd);
    stat.div_done  = div_done;
    stat.h_last    = (hk_r == 2'd2);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_curve_value = out_r;
  assign out_valid       = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/tcse_ctrl.sv @@
// Controller state machine: sequences the table search, point fetch,
// divisions and Horner steps in tcse_dp. Depends on tcse_pkg.
`default_nettype none
module tcse_ctrl
  import tcse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_req_type,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_WRITE) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op    = OP_START;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd.op    = OP_FIRST;
        state_nxt = (stat.n_zero || stat.lt) ? ST_DONE : ST_LAST;
      end
      ST_LAST: begin
        cmd.op    = OP_LAST;
        state_nxt = stat.lt ? ST_SRCH : ST_DONE;
      end
      ST_SRCH: begin
        cmd.op = OP_SRCH;
        if (stat.srch_done) state_nxt = ST_F0;
      end
      ST_F0: begin cmd.op = OP_LD0; state_nxt = ST_F1; end
      ST_F1: begin cmd.op = OP_LD1; state_nxt = ST_F2; end
      ST_F2: begin cmd.op = OP_LD2; state_nxt = ST_F3; end
      ST_F3: begin cmd.op = OP_LD3; state_nxt = ST_T_GO; end
      ST_T_GO: begin cmd.op = OP_DT_GO; state_nxt = ST_T_WAIT; end
      ST_T_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_CAP_T;
          state_nxt = ST_M1_MUL;
        end
      end
      ST_M1_MUL: begin cmd.op = OP_MUL_M1; state_nxt = ST_M1_GO; end
      ST_M1_GO: begin cmd.op = OP_DM1_GO; state_nxt = ST_M1_WAIT; end
      ST_M1_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_CAP_M1;
          state_nxt = ST_M2_MUL;
        end
      end
      ST_M2_MUL: begin cmd.op = OP_MUL_M2; state_nxt = ST_M2_GO; end
      ST_M2_GO: begin cmd.op = OP_DM2_GO; state_nxt = ST_M2_WAIT; end
      ST_M2_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_CAP_M2;
          state_nxt = ST_COEF;
        end
      end
      ST_COEF: begin cmd.op = OP_COEF; state_nxt = ST_HMUL; end
      ST_HMUL: begin cmd.op = OP_HMUL; state_nxt = ST_HADD; end
      ST_HADD: begin
        cmd.op    = OP_HADD;
        state_nxt = stat.h_last ? ST_CLAMP : ST_HMUL;
      end
      ST_CLAMP: begin cmd.op = OP_CLAMP; state_nxt = ST_DONE; end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/tone_curve_spline_evaluator_core.sv @@
// Top level of the tone curve spline evaluator.
// Joins the controller tcse_ctrl and the datapath tcse_dp. Depends on tcse_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): each item either writes a control
//   point (in_req_type = 0, slot in_point_index, coordinates saturated to
//   1.0) or evaluates the curve at in_sample_x (in_req_type = 1).
//   Output channel (out_valid/out_ready): one item per evaluate request,
//   out_curve_value in unsigned Q1.16.
//   Config channel (cfg_valid/cfg_ready): writes point_count, always ready;
//   write it only while the block is idle.
// Timing:
//   An evaluate item that falls outside the point span skips the search and
//   the divisions; otherwise the search walks the table one knot per cycle
//   and the shared divider produces one quotient bit per cycle for three
//   divisions. One item is in work at a time.
// Reset: point_count returns to 2, the output register empties; the point
//   tables hold no defined value until written.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile, and its result holds until the register is free.
`default_nettype none
module tone_curve_spline_evaluator_core
  import tcse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_req_type,
  input  wire logic [IdxW-1:0] in_point_index,
  input  wire logic [ValW-1:0] in_point_x,
  input  wire logic [ValW-1:0] in_point_y,
  input  wire logic [ValW-1:0] in_sample_x,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [ValW-1:0]      out_curve_value,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [CntW-1:0] cfg_point_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tcse_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  tcse_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_point_index  (in_point_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_sample_x     (in_sample_x),
    .cfg_valid       (cfg_valid),
    .cfg_point_count (cfg_point_count),
    .out_curve_value (out_curve_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule
`default_nettype wire
